>>> sv/seglcd_pkg.sv
// Shared types, request codes and digit tables for the segment LCD buffer.
// No dependencies; every other file imports this package.
`default_nettype none

package seglcd_pkg;

   localparam int STORE_WORDS = 8;
   localparam int WORD_BITS   = 16;
   localparam int STORE_BITS  = STORE_WORDS * WORD_BITS;
   localparam int ADDR_W      = $clog2(STORE_WORDS);

   localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(STORE_WORDS - 1);

   // request codes
   localparam logic [2:0] REQ_SYMBOL = 3'd0;
   localparam logic [2:0] REQ_DIGIT  = 3'd1;
   localparam logic [2:0] REQ_CLEAR  = 3'd2;
   localparam logic [2:0] REQ_CMD    = 3'd3;
   localparam logic [2:0] REQ_NIBBLE = 3'd4;

   // frame constants
   localparam logic [15:0] HEADER_BITS  = 16'h0005;
   localparam logic [4:0]  HEADER_COUNT = 5'd9;
   localparam logic [4:0]  WORD_COUNT   = 5'd16;
   localparam logic [4:0]  CMD_COUNT    = 5'd12;
   localparam logic [4:0]  NIBBLE_COUNT = 5'd13;

   localparam logic [15:0] WORD_RESET_LOW  = 16'd10;
   localparam logic [15:0] WORD_RESET_HIGH = 16'd0;

   // digit layout
   localparam logic [7:0] SEG_MASK_A = 8'hEF;
   localparam logic [7:0] SEG_MASK_B = 8'h7F;
   localparam logic [2:0] EXTRA_A    = 3'd4;
   localparam logic [2:0] EXTRA_B    = 3'd7;
   localparam logic [3:0] CODE_BLANK = 4'd15;

   typedef struct packed {
      logic [2:0] req_type;
      logic [6:0] symbol_index;
      logic [3:0] digit_position;
      logic [3:0] digit_code;
      logic       show;
      logic [7:0] command_byte;
      logic [5:0] nibble_address;
      logic [3:0] nibble_data;
   } seglcd_req_type;

   typedef struct packed {
      logic [15:0] frame_bits;
      logic [4:0]  bit_count;
      logic        end_of_frame;
   } seglcd_rsp_type;

   // bits to clear, then bits to set, across the whole store
   typedef struct packed {
      logic [STORE_BITS-1:0] clr;
      logic [STORE_BITS-1:0] set;
   } seglcd_upd_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
      logic [WORD_BITS-1:0] data;
   } seglcd_wr_type;

   function automatic logic [7:0] table_a(input logic [3:0] code);
      logic [7:0] pat;
      case (code)
         4'd0: pat = 8'hEB;
         4'd1: pat = 8'h60;
         4'd2: pat = 8'hC7;
         4'd3: pat = 8'hE5;
         4'd4: pat = 8'h6C;
         4'd5: pat = 8'hAD;
         4'd6: pat = 8'hAF;
         4'd7: pat = 8'hE0;
         4'd8: pat = 8'hEF;
         4'd9: pat = 8'hED;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

   function automatic logic [7:0] table_b(input logic [3:0] code);
      logic [7:0] pat;
      case (code)
         4'd0: pat = 8'h7D;
         4'd1: pat = 8'h60;
         4'd2: pat = 8'h3E;
         4'd3: pat = 8'h7A;
         4'd4: pat = 8'h63;
         4'd5: pat = 8'h5B;
         4'd6: pat = 8'h5F;
         4'd7: pat = 8'h70;
         4'd8: pat = 8'h7F;
         4'd9: pat = 8'h7B;
         default: pat = 8'h00;
      endcase
      return pat;
   endfunction

   // bit offset of the wide digit places 4 to 9
   function automatic logic [6:0] wide_offset(input logic [3:0] place);
      logic [6:0] off;
      case (place)
         4'd4: off = 7'd44;
         4'd5: off = 7'd52;
         4'd6: off = 7'd60;
         4'd7: off = 7'd76;
         4'd8: off = 7'd84;
         4'd9: off = 7'd92;
         default: off = 7'd0;
      endcase
      return off;
   endfunction

endpackage

`default_nettype wire

>>> sv/segment_lcd_buffer_serial_writer_unit.sv
// Segment LCD buffer with serial frame writer: top level and refresh sequencer.
// Depends on seglcd_pkg, seglcd_decode and seglcd_store.
`default_nettype none

// A request is taken when start is high and busy is low. Symbol, digit and
// clear-all requests each produce a refresh frame of nine chunks on
// consecutive cycles: the header chunk, then the eight store words, one word
// read, modified and written back per cycle through the single read port of
// the store RAM. Such a request holds busy until the last word; busy drops
// during the last word so the next request is taken without a gap. Raw
// command and raw nibble requests give one chunk and do not raise busy. Each
// chunk is built in the header, word or raw state and then registered onto
// rsp_payload, where it shows for exactly one cycle under rsp_strobe; the
// receiver cannot stall the block and must take every chunk as it comes.
// Unknown request types are taken and dropped without any chunk.
module segment_lcd_buffer_serial_writer_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire seglcd_pkg::seglcd_req_type req_payload,
   output logic                            rsp_strobe,
   output seglcd_pkg::seglcd_rsp_type      rsp_payload
);
   import seglcd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_HEAD = 4'b0010,
      ST_WORD = 4'b0100,
      ST_RAW  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    word_ff, word_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   seglcd_rsp_type       rsp_ff, rsp_in;
   seglcd_upd_type       upd_ff, upd_in;
   seglcd_rsp_type       raw_ff, raw_in;

   seglcd_upd_type       dec_upd;
   seglcd_rsp_type       dec_raw;
   seglcd_wr_type        wr;
   logic [ADDR_W-1:0]    rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic [WORD_BITS-1:0] clr_word;
   logic [WORD_BITS-1:0] set_word;
   logic [WORD_BITS-1:0] new_word;
   logic                 accept;

   seglcd_decode u_decode (
      .req (req_payload),
      .upd (dec_upd),
      .raw (dec_raw)
   );

   seglcd_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (wr)
   );

   assign busy   = (state_ff == ST_HEAD) || (state_ff == ST_WORD && word_ff != LAST_WORD);
   assign accept = start && !busy;

   assign clr_word = upd_ff.clr[{word_ff, 4'b0000} +: WORD_BITS];
   assign set_word = upd_ff.set[{word_ff, 4'b0000} +: WORD_BITS];
   assign new_word = (rd_data & ~clr_word) | set_word;

   assign upd_in = accept ? dec_upd : upd_ff;
   assign raw_in = accept ? dec_raw : raw_ff;

   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = '0;
      wr.en        = 1'b0;
      wr.addr      = word_ff;
      wr.data      = new_word;

      unique case (state_ff)
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         ST_HEAD: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{frame_bits: HEADER_BITS, bit_count: HEADER_COUNT,
                             end_of_frame: 1'b0};
            rd_addr      = '0;
            word_in      = '0;
            state_in     = ST_WORD;
         end
         ST_WORD: begin
            // write back the modified word and fetch the next one
            wr.en        = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_in       = '{frame_bits: new_word, bit_count: WORD_COUNT,
                             end_of_frame: (word_ff == LAST_WORD)};
            rd_addr      = word_ff + ADDR_W'(1);
            word_in      = word_ff + ADDR_W'(1);
            if (word_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_RAW: begin
            rsp_valid_in = 1'b1;
            rsp_in       = raw_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (accept) begin
         case (req_payload.req_type) inside
            REQ_SYMBOL, REQ_DIGIT, REQ_CLEAR: state_in = ST_HEAD;
            REQ_CMD, REQ_NIBBLE:              state_in = ST_RAW;
            default:                          state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      upd_ff <= upd_in;
      raw_ff <= raw_in;
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

>>> sv/seglcd_store.sv
// Segment store: eight 16-bit words in a synchronous RAM, one read and one write port.
// Per-word valid bits give the reset contents until a word is first written.
// Depends on seglcd_pkg.
`default_nettype none

module seglcd_store (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [seglcd_pkg::ADDR_W-1:0]    rd_addr,
   output logic      [seglcd_pkg::WORD_BITS-1:0] rd_data,
   input  wire seglcd_pkg::seglcd_wr_type        wr
);
   import seglcd_pkg::*;

   logic [WORD_BITS-1:0]   mem [STORE_WORDS];
   logic [STORE_WORDS-1:0] valid_ff;
   logic [WORD_BITS-1:0]   rd_word_ff;
   logic                   rd_valid_ff;
   logic [ADDR_W-1:0]      rd_addr_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_word_ff <= mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // unwritten words read as their reset value: low half of the store holds 10
   always_comb begin
      if (rd_valid_ff) begin
         rd_data = rd_word_ff;
      end else if (rd_addr_ff < ADDR_W'(STORE_WORDS / 2)) begin
         rd_data = WORD_RESET_LOW;
      end else begin
         rd_data = WORD_RESET_HIGH;
      end
   end

endmodule

`default_nettype wire

>>> sv/seglcd_decode.sv
// Request decoder: turns one request into store clear/set masks and a raw frame chunk.
// Depends on seglcd_pkg (tables, codes, structs).
`default_nettype none

module seglcd_decode (
   input  wire seglcd_pkg::seglcd_req_type req,
   output seglcd_pkg::seglcd_upd_type      upd,
   output seglcd_pkg::seglcd_rsp_type      raw
);
   import seglcd_pkg::*;

   logic [STORE_BITS-1:0] one_hot;
   logic [6:0]            offset;
   logic [7:0]            seg_mask;
   logic [7:0]            pattern;
   logic [2:0]            extra;
   logic                  place_ok;
   logic                  known;
   logic [STORE_BITS-1:0] seg_wide;
   logic [STORE_BITS-1:0] pat_wide;
   logic [STORE_BITS-1:0] extra_wide;

   assign one_hot = {{(STORE_BITS-1){1'b0}}, 1'b1} << req.symbol_index;
   assign known   = (req.digit_code < 4'd10);

   always_comb begin
      if (req.digit_position < 4'd4) begin
         place_ok = 1'b1;
         offset   = {req.digit_position[1:0], 3'b000};
         seg_mask = SEG_MASK_A;
         extra    = EXTRA_A;
         pattern  = table_a(req.digit_code);
      end else if (req.digit_position < 4'd10) begin
         place_ok = 1'b1;
         offset   = wide_offset(req.digit_position);
         seg_mask = SEG_MASK_B;
         extra    = EXTRA_B;
         pattern  = table_b(req.digit_code);
      end else begin
         place_ok = 1'b0;
         offset   = 7'd0;
         seg_mask = 8'h00;
         extra    = 3'd0;
         pattern  = 8'h00;
      end
   end

   assign seg_wide   = STORE_BITS'(seg_mask) << offset;
   assign pat_wide   = STORE_BITS'(pattern & seg_mask) << offset;
   assign extra_wide = STORE_BITS'(8'h01 << extra) << offset;

   always_comb begin
      upd.clr = '0;
      upd.set = '0;
      unique case (req.req_type)
         REQ_SYMBOL: begin
            upd.clr = one_hot;
            upd.set = req.show ? one_hot : '0;
         end
         REQ_DIGIT: begin
            if (place_ok) begin
               upd.clr = seg_wide;
               if (req.show && req.digit_code == CODE_BLANK) begin
                  upd.clr = seg_wide | extra_wide;
               end
               if (req.show && known) begin
                  upd.set = pat_wide;
               end
            end
         end
         REQ_CLEAR: begin
            upd.clr = '1;
         end
         default: begin
            upd.clr = '0;
         end
      endcase
   end

   // raw frames: start bits, address or command MSB first, data LSB first
   always_comb begin
      raw.end_of_frame = 1'b1;
      if (req.req_type == REQ_NIBBLE) begin
         raw.frame_bits = {3'b000, req.nibble_data,
                           req.nibble_address[0], req.nibble_address[1],
                           req.nibble_address[2], req.nibble_address[3],
                           req.nibble_address[4], req.nibble_address[5],
                           3'b101};
         raw.bit_count  = NIBBLE_COUNT;
      end else begin
         raw.frame_bits = {4'b0000, req.command_byte[0],
                           req.command_byte[0], req.command_byte[1],
                           req.command_byte[2], req.command_byte[3],
                           req.command_byte[4], req.command_byte[5],
                           req.command_byte[6], req.command_byte[7],
                           3'b001};
         raw.bit_count  = CMD_COUNT;
      end
   end

endmodule

`default_nettype wire
